@@ rtl/core/tplca_pkg.sv @@
// Shared constants and types for the tree path length / LCA block.
`default_nettype none
package tplca_pkg;

  localparam int NODE_COUNT_DEF = 65536;
  localparam int LEVELS_DEF     = 16;

  localparam int NODE_W  = 16;
  localparam int LEN_W   = 30;
  localparam int DEPTH_W = 16;
  localparam int DIST_W  = 46;
  localparam int PATH_W  = 48;
  localparam int INFO_W  = DEPTH_W + DIST_W;

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_QUERY = 1'b1
  } opcode_t;

endpackage
`default_nettype wire

@@ rtl/core/tplca_if.sv @@
// Valid/ready channel interfaces for input and result words.
`default_nettype none
interface tplca_in_if
  import tplca_pkg::*;
();
  logic        valid;
  logic        ready;
  opcode_t     opcode;
  logic [15:0] first_node;
  logic [15:0] second_node;
  logic [29:0] edge_length;

  modport source (output valid, output opcode, output first_node, output second_node,
                  output edge_length, input ready);
  modport sink   (input valid, input opcode, input first_node, input second_node,
                  input edge_length, output ready);
endinterface

interface tplca_out_if
  import tplca_pkg::*;
();
  logic        valid;
  logic        ready;
  logic [47:0] path_length;

  modport source (output valid, output path_length, input ready);
  modport sink   (input valid, input path_length, output ready);
endinterface
`default_nettype wire

@@ rtl/core/tree_path_length_lca.sv @@
// Top level: weighted tree store with binary-lifting LCA path length queries.
`default_nettype none
// Keeps a rooted weighted tree (node 0 is the root, with depth 0, distance 0
// and all ancestors 0) and answers path length queries between two nodes.
// An add word (opcode 0) gives node, parent and edge length; the block stores
// depth, distance from the root and the row of LEVELS ancestors (2^i-th
// ancestor at level i). Parents must be added before their children. An add
// of node 0, or with node or parent not below NODE_COUNT, is dropped. A query
// word (opcode 1) returns dist(a)+dist(b)-2*dist(lca), or 0 when a node is
// out of range or the tree is inconsistent and that difference would go
// negative. Depth saturates at 65535 and distance at 2^46-1.
// One word is worked at a time. Everything goes through the single read port
// of the ancestor memory (NODE_COUNT x 2^ceil(log2 LEVELS) x 16 bits) and of
// the node info memory (NODE_COUNT x 62 bits, depth and distance), both with
// a registered read; node 0 is never stored, reads of it return zeros.
// Steps per word, from acceptance back to ready:
//   add:   the info write, then one read and one write per ancestor level
//   query: two info reads and a lift of the deeper node over the depth
//          difference, then a joint lift and a parent read when the nodes
//          are not in an ancestor line; an out-of-range query skips to the result.
// A query also waits in its last state while the output register is full.
// A result waits in the output register while the next word is accepted.
// Memories hold no reset state, so there is no clearing pass.
module tree_path_length_lca
  import tplca_pkg::*;
#(
  parameter int NODE_COUNT = NODE_COUNT_DEF,
  parameter int LEVELS     = LEVELS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  tplca_in_if.sink    in_w,
  tplca_out_if.source out_w
);
  localparam int NW      = $clog2(NODE_COUNT);
  localparam int LW      = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int AAW     = NW + LW;
  localparam int ADEPTH  = NODE_COUNT * (1 << LW);
  localparam int SUM_W   = DIST_W + 1;
  localparam logic [LW-1:0] LVL_TOP = LW'(LEVELS - 1);

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_A_INFO = 16'h0002,
    S_A_RD   = 16'h0004,
    S_A_WR   = 16'h0008,
    S_Q_RB   = 16'h0010,
    S_Q_SW   = 16'h0020,
    S_Q_L1   = 16'h0040,
    S_Q_L1W  = 16'h0080,
    S_Q_CHK  = 16'h0100,
    S_Q_L2A  = 16'h0200,
    S_Q_L2B  = 16'h0400,
    S_Q_L2C  = 16'h0800,
    S_Q_PAR  = 16'h1000,
    S_Q_PARW = 16'h2000,
    S_Q_LW   = 16'h4000,
    S_Q_FIN  = 16'h8000
  } state_t;

  state_t state_r, state_nxt;

  // working registers
  logic [NODE_W-1:0]  a_r, a_nxt, b_r, b_nxt;
  logic [NODE_W-1:0]  node_r, node_nxt, up_r, up_nxt, pa_r, pa_nxt;
  logic [LW-1:0]      lvl_r, lvl_nxt;
  logic [DEPTH_W-1:0] diff_r, diff_nxt, da_r, da_nxt;
  logic [DIST_W-1:0]  dista_r, dista_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [PATH_W-1:0]  res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [PATH_W-1:0]  out_data_r, out_data_nxt;

  // memory ports
  logic               anc_we;
  logic [NODE_W-1:0]  anc_wnode, anc_rnode, anc_wdata, anc_rdata, anc_q;
  logic [LW-1:0]      anc_wlvl, anc_rlvl;
  logic               anc_z_r;
  logic               info_we;
  logic [NODE_W-1:0]  info_wnode, info_rnode;
  logic [INFO_W-1:0]  info_wdata, info_rdata, info_q;
  logic               info_z_r;

  logic [DEPTH_W-1:0] q_depth;
  logic [DIST_W-1:0]  q_dist;
  logic [SUM_W-1:0]   dist_sum, twice;
  logic [31:0]        diff_sh;
  logic               in_ok_1, in_ok_2, out_free;

  tplca_ram #(.WIDTH(NODE_W), .DEPTH(ADEPTH)) u_anc_ram (
    .clk   (clk),
    .we    (anc_we),
    .waddr ({NW'(anc_wnode), anc_wlvl}),
    .wdata (anc_wdata),
    .raddr ({NW'(anc_rnode), anc_rlvl}),
    .rdata (anc_rdata)
  );

  tplca_ram #(.WIDTH(INFO_W), .DEPTH(NODE_COUNT)) u_info_ram (
    .clk   (clk),
    .we    (info_we),
    .waddr (NW'(info_wnode)),
    .wdata (info_wdata),
    .raddr (NW'(info_rnode)),
    .rdata (info_rdata)
  );

  // root entries are never stored; force them to zero on read
  assign anc_q   = anc_z_r ? '0 : anc_rdata;
  assign info_q  = info_z_r ? '0 : info_rdata;
  assign q_depth = info_q[INFO_W-1 -: DEPTH_W];
  assign q_dist  = info_q[DIST_W-1:0];

  assign in_ok_1  = 32'(in_w.first_node) < NODE_COUNT;
  assign in_ok_2  = 32'(in_w.second_node) < NODE_COUNT;
  assign out_free = !out_valid_r || out_w.ready;
  assign diff_sh  = 32'(diff_r) >> lvl_r;

  assign in_w.ready        = (state_r == S_IDLE);
  assign out_w.valid       = out_valid_r;
  assign out_w.path_length = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    node_nxt      = node_r;
    up_nxt        = up_r;
    pa_nxt        = pa_r;
    lvl_nxt       = lvl_r;
    diff_nxt      = diff_r;
    da_nxt        = da_r;
    dista_nxt     = dista_r;
    sum_nxt       = sum_r;
    len_nxt       = len_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_w.ready;
    out_data_nxt  = out_data_r;
    anc_we        = 1'b0;
    anc_wnode     = node_r;
    anc_wlvl      = lvl_r;
    anc_wdata     = anc_q;
    anc_rnode     = a_r;
    anc_rlvl      = lvl_r;
    info_we       = 1'b0;
    info_wnode    = node_r;
    info_wdata    = '0;
    info_rnode    = a_r;
    dist_sum      = '0;
    twice         = '0;

    case (state_r)
      S_IDLE: begin
        if (in_w.valid) begin
          if (in_w.opcode == OP_ADD) begin
            if (in_w.first_node != '0 && in_ok_1 && in_ok_2) begin
              anc_we     = 1'b1;
              anc_wnode  = in_w.first_node;
              anc_wlvl   = '0;
              anc_wdata  = in_w.second_node;
              info_rnode = in_w.second_node;
              node_nxt   = in_w.first_node;
              up_nxt     = in_w.second_node;
              len_nxt    = in_w.edge_length;
              lvl_nxt    = LW'(1);
              state_nxt  = S_A_INFO;
            end
          end else if (in_ok_1 && in_ok_2) begin
            a_nxt      = in_w.first_node;
            b_nxt      = in_w.second_node;
            info_rnode = in_w.first_node;
            state_nxt  = S_Q_RB;
          end else begin
            res_nxt   = '0;
            state_nxt = S_Q_FIN;
          end
        end
      end
      S_A_INFO: begin
        dist_sum   = SUM_W'(q_dist) + SUM_W'(len_r);
        info_we    = 1'b1;
        info_wdata = {(q_depth == '1) ? q_depth : q_depth + 1'b1,
                      dist_sum[DIST_W] ? {DIST_W{1'b1}} : dist_sum[DIST_W-1:0]};
        state_nxt  = (LEVELS > 1) ? S_A_RD : S_IDLE;
      end
      S_A_RD: begin
        anc_rnode = up_r;
        anc_rlvl  = lvl_r - 1'b1;
        state_nxt = S_A_WR;
      end
      S_A_WR: begin
        anc_we    = 1'b1;
        anc_wdata = anc_q;
        up_nxt    = anc_q;
        if (lvl_r == LVL_TOP) begin
          state_nxt = S_IDLE;
        end else begin
          lvl_nxt   = lvl_r + 1'b1;
          state_nxt = S_A_RD;
        end
      end
      S_Q_RB: begin
        da_nxt     = q_depth;
        dista_nxt  = q_dist;
        info_rnode = b_r;
        state_nxt  = S_Q_SW;
      end
      S_Q_SW: begin
        sum_nxt = SUM_W'(dista_r) + SUM_W'(q_dist);
        if (da_r < q_depth) begin
          a_nxt    = b_r;
          b_nxt    = a_r;
          diff_nxt = q_depth - da_r;
        end else begin
          diff_nxt = da_r - q_depth;
        end
        lvl_nxt   = LVL_TOP;
        state_nxt = S_Q_L1;
      end
      S_Q_L1: begin
        if (diff_sh[0]) begin
          state_nxt = S_Q_L1W;
        end else if (lvl_r == '0) begin
          state_nxt = S_Q_CHK;
        end else begin
          lvl_nxt = lvl_r - 1'b1;
        end
      end
      S_Q_L1W: begin
        a_nxt = anc_q;
        if (lvl_r == '0) begin
          state_nxt = S_Q_CHK;
        end else begin
          lvl_nxt   = lvl_r - 1'b1;
          state_nxt = S_Q_L1;
        end
      end
      S_Q_CHK: begin
        if (a_r == b_r) begin
          info_rnode = a_r;
          state_nxt  = S_Q_LW;
        end else begin
          lvl_nxt   = LVL_TOP;
          state_nxt = S_Q_L2A;
        end
      end
      S_Q_L2A: begin
        state_nxt = S_Q_L2B;
      end
      S_Q_L2B: begin
        pa_nxt    = anc_q;
        anc_rnode = b_r;
        state_nxt = S_Q_L2C;
      end
      S_Q_L2C: begin
        if (pa_r != anc_q) begin
          a_nxt = pa_r;
          b_nxt = anc_q;
        end
        if (lvl_r == '0) begin
          state_nxt = S_Q_PAR;
        end else begin
          lvl_nxt   = lvl_r - 1'b1;
          state_nxt = S_Q_L2A;
        end
      end
      S_Q_PAR: begin
        anc_rlvl  = '0;
        state_nxt = S_Q_PARW;
      end
      S_Q_PARW: begin
        info_rnode = anc_q;
        state_nxt  = S_Q_LW;
      end
      S_Q_LW: begin
        twice     = {q_dist, 1'b0};
        res_nxt   = (twice > sum_r) ? '0 : PATH_W'(sum_r - twice);
        state_nxt = S_Q_FIN;
      end
      S_Q_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    node_r     <= node_nxt;
    up_r       <= up_nxt;
    pa_r       <= pa_nxt;
    lvl_r      <= lvl_nxt;
    diff_r     <= diff_nxt;
    da_r       <= da_nxt;
    dista_r    <= dista_nxt;
    sum_r      <= sum_nxt;
    len_r      <= len_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    anc_z_r    <= (anc_rnode == '0);
    info_z_r   <= (info_rnode == '0);
  end

`ifndef SYNTHESIS
  // the root row is implicit and must never be written
  a_anc_no_root: assert property (@(posedge clk) disable iff (!rst_n)
    anc_we |-> anc_wnode != '0)
    else $error("ancestor write to root");

  a_info_no_root: assert property (@(posedge clk) disable iff (!rst_n)
    info_we |-> info_wnode != '0)
    else $error("info write to root");

  // level counter is only loaded from the add and lift states
  a_lvl_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE && state_r != S_Q_FIN && state_r != S_Q_RB &&
     state_r != S_Q_SW) |-> 32'(lvl_r) < LEVELS)
    else $error("level counter out of range");

  a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_Q_FIN && out_free) |=> (out_valid_r && state_r == S_IDLE))
    else $error("result not loaded");
`endif
endmodule
`default_nettype wire

@@ rtl/core/tplca_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read.
`default_nettype none
module tplca_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire
